>>> hw/rtl/tpie_pkg.sv
// ----------------------------------------------------------------------------
// tpie_pkg
// Shared types and constants for the triangle pair index encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpie_pkg;

  localparam int CODE_BITS = 16;
  localparam int CODE_BIAS = 3;
  localparam int MAX_CODES = 6;
  localparam int LAST_POS  = 5;
  localparam int CNT_BITS  = 3;
  localparam int POS_BITS  = 3;

  // number of codes one item produces
  localparam logic [CNT_BITS-1:0] CNT_NONE   = 3'd0;
  localparam logic [CNT_BITS-1:0] CNT_SINGLE = 3'd3;
  localparam logic [CNT_BITS-1:0] CNT_PAIR   = 3'd4;
  localparam logic [CNT_BITS-1:0] CNT_DOUBLE = 3'd6;

  typedef struct packed {
    logic [CNT_BITS-1:0] cnt;    // codes in this job
    logic                clear;  // end of part: zero the watermark after the job
  } job_ctl_t;

  // next corner position, mod 3
  function automatic logic [1:0] nxt3(input logic [1:0] x);
    nxt3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/triangle_pair_index_encoder_top.sv
// ----------------------------------------------------------------------------
// triangle_pair_index_encoder_top
// Pairs triangles on shared edges and emits high-watermark index codes.
// ----------------------------------------------------------------------------
// One triangle is taken per item and yields 0, 3, 4 or 6 codes, sent one per
// cycle from the output register while out_stall is low; the code emitter sets
// the rate, and the next item is accepted in the cycle the current job's last
// code is issued. A triangle that only becomes pending still occupies the job
// slot.
`default_nettype none

module triangle_pair_index_encoder_top #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [INDEX_BITS-1:0] corner_a,
  input  wire logic [INDEX_BITS-1:0] corner_b,
  input  wire logic [INDEX_BITS-1:0] corner_c,
  input  wire logic                  part_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [tpie_pkg::CODE_BITS-1:0] code,
  output logic                       last
);

  logic                                        take;
  logic                                        busy;
  logic [tpie_pkg::LAST_POS:0][INDEX_BITS-1:0] job_idx;
  tpie_pkg::job_ctl_t                          job_ctl;

  assign in_stall = busy;
  assign take     = in_valid && !busy;

  tpie_pair #(.IW(INDEX_BITS)) u_pair (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .corner_a (corner_a),
    .corner_b (corner_b),
    .corner_c (corner_c),
    .part_end (part_end),
    .job_idx  (job_idx),
    .job_ctl  (job_ctl)
  );

  tpie_emit #(.IW(INDEX_BITS)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .job_idx_in (job_idx),
    .job_ctl_in (job_ctl),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code       (code),
    .last       (last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tpie_pair.sv
// ----------------------------------------------------------------------------
// tpie_pair
// Rotates the incoming triangle, pairs it with the pending one on a shared
// mirrored edge, and builds the list of indices to be coded for this item.
// ----------------------------------------------------------------------------
`default_nettype none

module tpie_pair #(
  parameter int IW = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire logic [IW-1:0]          corner_a,
  input  wire logic [IW-1:0]          corner_b,
  input  wire logic [IW-1:0]          corner_c,
  input  wire logic                   part_end,
  output logic [tpie_pkg::LAST_POS:0][IW-1:0] job_idx,
  output tpie_pkg::job_ctl_t          job_ctl
);

  logic [2:0][IW-1:0] held;
  logic               held_valid;
  logic               held_valid_next;
  logic               store_new;

  logic [2:0][IW-1:0] t;
  logic [1:0]         m;
  logic               found;
  logic [1:0]         ej;
  logic [1:0]         ek;
  logic [IW-1:0]      e0, e1, opp_held, opp_new;

  // rotate so the smallest index leads; earliest position wins ties
  always_comb begin
    m = 2'd0;
    if (corner_b < corner_a) m = 2'd1;
    if (corner_c < ((m == 2'd1) ? corner_b : corner_a)) m = 2'd2;
    case (m)
      2'd1:    t = {corner_a, corner_c, corner_b};
      2'd2:    t = {corner_b, corner_a, corner_c};
      default: t = {corner_c, corner_b, corner_a};
    endcase
  end

  // first edge of the pending triangle that shows up mirrored in the new one
  always_comb begin
    found = 1'b0;
    ej    = 2'd0;
    ek    = 2'd0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (!found && t[k] == held[(j + 1) % 3] && t[(k + 1) % 3] == held[j]) begin
          found = 1'b1;
          ej    = 2'(j);
          ek    = 2'(k);
        end
      end
    end
    found = found && held_valid;
  end

  always_comb begin
    e0       = held[ej];
    e1       = held[tpie_pkg::nxt3(ej)];
    opp_held = held[tpie_pkg::nxt3(tpie_pkg::nxt3(ej))];
    opp_new  = t[tpie_pkg::nxt3(tpie_pkg::nxt3(ek))];
  end

  always_comb begin
    job_idx         = '0;
    job_ctl.cnt     = tpie_pkg::CNT_NONE;
    job_ctl.clear   = part_end;
    store_new       = 1'b1;
    held_valid_next = !part_end;
    if (found) begin
      store_new       = 1'b0;
      held_valid_next = 1'b0;
      job_ctl.cnt     = tpie_pkg::CNT_PAIR;
      if (e0 < e1) begin
        job_idx[0] = e0;
        job_idx[1] = e1;
        job_idx[2] = opp_held;
        job_idx[3] = opp_new;
      end else begin
        job_idx[0] = e1;
        job_idx[1] = e0;
        job_idx[2] = opp_new;
        job_idx[3] = opp_held;
      end
    end else if (held_valid) begin
      job_idx[0]  = held[2];
      job_idx[1]  = held[0];
      job_idx[2]  = held[1];
      job_ctl.cnt = tpie_pkg::CNT_SINGLE;
      if (part_end) begin
        job_idx[3]  = t[2];
        job_idx[4]  = t[0];
        job_idx[5]  = t[1];
        job_ctl.cnt = tpie_pkg::CNT_DOUBLE;
      end
    end else if (part_end) begin
      job_idx[0]  = t[2];
      job_idx[1]  = t[0];
      job_idx[2]  = t[1];
      job_ctl.cnt = tpie_pkg::CNT_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && store_new) begin
      held <= t;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tpie_emit.sv
// ----------------------------------------------------------------------------
// tpie_emit
// Holds one job and turns its indices into watermark codes, one per cycle
// while the output is not stalled, through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpie_emit #(
  parameter int IW = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire logic [tpie_pkg::LAST_POS:0][IW-1:0] job_idx_in,
  input  wire tpie_pkg::job_ctl_t     job_ctl_in,
  output logic                        busy,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [tpie_pkg::CODE_BITS-1:0] code,
  output logic                        last
);

  localparam int CW = (IW > tpie_pkg::CODE_BITS) ? IW : tpie_pkg::CODE_BITS;

  logic [tpie_pkg::LAST_POS:0][IW-1:0] job_idx;
  tpie_pkg::job_ctl_t                   job_ctl;
  logic                                 job_valid;
  logic [tpie_pkg::POS_BITS-1:0]        pos;
  logic [IW-1:0]                        hm;

  logic          no_codes;
  logic          advance;
  logic          last_step;
  logic          job_done;
  logic [IW-1:0] idx;
  logic [CW-1:0] code_full;

  always_comb begin
    no_codes  = (job_ctl.cnt == tpie_pkg::CNT_NONE);
    advance   = job_valid && (no_codes || !out_valid || !out_stall);
    last_step = no_codes || (pos == job_ctl.cnt - 3'd1);
    job_done  = advance && last_step;
    busy      = job_valid && !job_done;
    idx       = job_idx[pos];
    code_full = CW'(hm) + CW'(tpie_pkg::CODE_BIAS) - CW'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
      hm        <= '0;
    end else begin
      if (take) begin
        job_valid <= 1'b1;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end

      if (job_done) begin
        pos <= '0;
      end else if (advance) begin
        pos <= pos + 3'd1;
      end

      if (advance && !no_codes) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // watermark clears only after the last code of an end-of-part item
      if (advance) begin
        if (last_step && job_ctl.clear) begin
          hm <= '0;
        end else if (!no_codes && idx > hm) begin
          hm <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_idx <= job_idx_in;
      job_ctl <= job_ctl_in;
    end
    if (advance && !no_codes) begin
      code <= code_full[tpie_pkg::CODE_BITS-1:0];
      last <= last_step;
    end
  end

  a_pos_in_job: assert property (@(posedge clk) disable iff (rst)
    job_valid && !no_codes |-> pos < job_ctl.cnt)
    else $error("code position past end of job");

  a_cnt_legal: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_ctl.cnt == tpie_pkg::CNT_NONE || job_ctl.cnt == tpie_pkg::CNT_SINGLE ||
                   job_ctl.cnt == tpie_pkg::CNT_PAIR || job_ctl.cnt == tpie_pkg::CNT_DOUBLE))
    else $error("illegal code count in job");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code) && $stable(last))
    else $error("stalled code changed");

  a_clear_after_part: assert property (@(posedge clk) disable iff (rst)
    job_done && job_ctl.clear |=> hm == '0)
    else $error("watermark not cleared at end of part");

endmodule

`default_nettype wire
